// ===== src/variable_length_message_fifo_defines.svh =====
// ---------------------------------------------------------------------------
// Message FIFO assertion macros
// Shared property wrappers for the checker of the message FIFO.
// ---------------------------------------------------------------------------
`ifndef VARIABLE_LENGTH_MESSAGE_FIFO_DEFINES_SVH
`define VARIABLE_LENGTH_MESSAGE_FIFO_DEFINES_SVH

// Checked only outside reset.
`define VLMF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define VLMF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/vlmf_pkg.sv =====
// ---------------------------------------------------------------------------
// Message FIFO package
// Sizes, operation and status codes, and the structs shared by the modules.
// ---------------------------------------------------------------------------
package vlmf_pkg;

  localparam int CAPACITY   = 4096;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int POS_W      = ADDR_W + 1;
  localparam int LEN_W      = 12;
  localparam int CMD_W      = 32;
  localparam int BYTE_W     = 8;
  localparam int HDR_BYTES  = 8;
  localparam int SUM_W      = ((POS_W > LEN_W) ? POS_W : LEN_W) + 2;
  localparam int OP_W       = 3;
  localparam int ST_W       = 3;
  localparam int IN_DATA_W  = CMD_W + LEN_W + LEN_W + BYTE_W;
  localparam int OUT_FLD_W  = CMD_W + LEN_W + BYTE_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int PAD_W      = OUT_DATA_W - OUT_FLD_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUT_HDR,
    OP_PUT_BYTE,
    OP_GET_HDR,
    OP_GET_BYTE,
    OP_END,
    OP_RESET
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK,
    ST_FULL,
    ST_EMPTY,
    ST_TOO_LONG,
    ST_ENDED,
    ST_SEQ
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [CMD_W-1:0]   cmd;
    logic [LEN_W-1:0]   length;
    logic               from_ram;
    logic               last;
  } res_t;

  typedef struct packed {
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [BYTE_W-1:0]  wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
  } ram_req_t;

endpackage

// ===== src/vlmf_ram.sv =====
// ---------------------------------------------------------------------------
// Message FIFO byte store
// Simple dual-port RAM with one write port and one registered read port.
// ---------------------------------------------------------------------------
module vlmf_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/vlmf_ctrl.sv =====
// ---------------------------------------------------------------------------
// Message FIFO controller
// Ring counters, header sequencing over the byte store, and the result stage.
// ---------------------------------------------------------------------------
module vlmf_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  vlmf_pkg::op_t             op,
  input  logic [vlmf_pkg::CMD_W-1:0]  cmd_code,
  input  logic [vlmf_pkg::LEN_W-1:0]  message_length,
  input  logic [vlmf_pkg::LEN_W-1:0]  max_length,
  input  logic [vlmf_pkg::BYTE_W-1:0] data_byte,
  output logic                      p_valid,
  output vlmf_pkg::res_t            p_res,
  input  logic                      p_ready,
  output vlmf_pkg::ram_req_t        ram_req,
  input  logic [vlmf_pkg::BYTE_W-1:0] rd_data
);

  import vlmf_pkg::*;

  localparam int STEP_W = $clog2(HDR_BYTES + 1);
  localparam int HDR_W  = HDR_BYTES * BYTE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUT,
    S_GET,
    S_EVAL,
    S_EMIT
  } state_t;

  state_t               state;
  logic [STEP_W-1:0]    step;
  logic [HDR_W-1:0]     hdr;
  logic [LEN_W-1:0]     max_len;
  logic [POS_W-1:0]     write_total;
  logic [POS_W-1:0]     read_total;
  logic [POS_W-1:0]     write_cursor;
  logic [POS_W-1:0]     read_cursor;
  logic [LEN_W-1:0]     write_remaining;
  logic [LEN_W-1:0]     read_remaining;
  logic                 write_open;
  logic                 read_open;
  logic                 ended_flag;
  res_t                 emit_res;

  logic                 accept;
  logic [POS_W-1:0]     fill;
  logic [SUM_W-1:0]     msg_need;
  logic                 room_bad;
  logic [CMD_W-1:0]     hl;
  logic                 too_long;
  logic [POS_W-1:0]     hdr_wr_pos;
  logic [POS_W-1:0]     hdr_rd_pos;
  logic [POS_W-1:0]     write_next;
  logic [POS_W-1:0]     read_next;
  logic [POS_W-1:0]     read_body;
  res_t                 imm_res;
  logic                 imm_emit;
  logic                 p_load;

  always_comb begin
    s_tready   = (state == S_IDLE) && (!p_valid || p_ready);
    accept     = s_tvalid && s_tready;
    fill       = write_total - read_total;
    msg_need   = SUM_W'(message_length) + SUM_W'(HDR_BYTES);
    room_bad   = (msg_need > SUM_W'(CAPACITY)) ||
                 ((SUM_W'(fill) + msg_need) > SUM_W'(CAPACITY));
    hl         = hdr[HDR_W-1:CMD_W];
    too_long   = hl > CMD_W'(max_len);
    hdr_wr_pos = write_total + POS_W'(step);
    hdr_rd_pos = read_total + POS_W'(step);
    write_next = write_cursor + POS_W'(1);
    read_next  = read_cursor + POS_W'(1);
    read_body  = read_total + POS_W'(HDR_BYTES);
  end

  always_comb begin
    imm_res  = '{status: ST_SEQ, cmd: '0, length: '0, from_ram: 1'b0, last: 1'b0};
    imm_emit = 1'b1;
    case (op)
      OP_PUT_HDR: begin
        if (write_open) begin
          imm_res.status = ST_SEQ;
        end else if (room_bad) begin
          imm_res.status = ST_FULL;
        end else begin
          imm_emit = 1'b0;
        end
      end
      OP_PUT_BYTE: begin
        if (write_open) begin
          imm_res.status = ST_OK;
        end
      end
      OP_GET_HDR: begin
        if (read_open) begin
          imm_res.status = ST_SEQ;
        end else if (fill == '0) begin
          imm_res.status = ended_flag ? ST_ENDED : ST_EMPTY;
        end else begin
          imm_emit = 1'b0;
        end
      end
      OP_GET_BYTE: begin
        if (read_open) begin
          imm_res.status   = ST_OK;
          imm_res.from_ram = 1'b1;
          imm_res.last     = (read_remaining == LEN_W'(1));
        end
      end
      OP_END:   imm_res.status = ST_OK;
      OP_RESET: imm_res.status = ST_OK;
      default:  imm_res.status = ST_SEQ;
    endcase
  end

  assign p_load = (accept && imm_emit) || ((state == S_EMIT) && (!p_valid || p_ready));

  always_comb begin
    ram_req = '0;
    if (state == S_PUT) begin
      ram_req.wr_en   = 1'b1;
      ram_req.wr_addr = hdr_wr_pos[ADDR_W-1:0];
      ram_req.wr_data = hdr[BYTE_W-1:0];
    end else if (accept && (op == OP_PUT_BYTE) && write_open) begin
      ram_req.wr_en   = 1'b1;
      ram_req.wr_addr = write_cursor[ADDR_W-1:0];
      ram_req.wr_data = data_byte;
    end
    if ((state == S_GET) && (step < STEP_W'(HDR_BYTES))) begin
      ram_req.rd_en   = 1'b1;
      ram_req.rd_addr = hdr_rd_pos[ADDR_W-1:0];
    end else if (accept && (op == OP_GET_BYTE) && read_open) begin
      ram_req.rd_en   = 1'b1;
      ram_req.rd_addr = read_cursor[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      step            <= '0;
      write_total     <= '0;
      read_total      <= '0;
      write_cursor    <= '0;
      read_cursor     <= '0;
      write_remaining <= '0;
      read_remaining  <= '0;
      write_open      <= 1'b0;
      read_open       <= 1'b0;
      ended_flag      <= 1'b0;
      p_valid         <= 1'b0;
    end else begin
      if (p_load) begin
        p_valid <= 1'b1;
      end else if (p_ready) begin
        p_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (imm_emit) begin
              p_res <= imm_res;
            end
            case (op)
              OP_PUT_HDR: begin
                if (!imm_emit) begin
                  hdr             <= {CMD_W'(message_length), cmd_code};
                  write_cursor    <= write_total + POS_W'(HDR_BYTES);
                  write_remaining <= message_length;
                  write_open      <= (message_length != '0);
                  step            <= '0;
                  state           <= S_PUT;
                end
              end
              OP_PUT_BYTE: begin
                if (write_open) begin
                  write_cursor    <= write_next;
                  write_remaining <= write_remaining - LEN_W'(1);
                  if (write_remaining == LEN_W'(1)) begin
                    write_total <= write_next;
                    write_open  <= 1'b0;
                  end
                end
              end
              OP_GET_HDR: begin
                if (!imm_emit) begin
                  max_len <= max_length;
                  step    <= '0;
                  state   <= S_GET;
                end
              end
              OP_GET_BYTE: begin
                if (read_open) begin
                  read_cursor    <= read_next;
                  read_remaining <= read_remaining - LEN_W'(1);
                  if (read_remaining == LEN_W'(1)) begin
                    read_total <= read_next;
                    read_open  <= 1'b0;
                  end
                end
              end
              OP_END: begin
                ended_flag <= 1'b1;
              end
              OP_RESET: begin
                write_total     <= '0;
                read_total      <= '0;
                write_cursor    <= '0;
                read_cursor     <= '0;
                write_remaining <= '0;
                read_remaining  <= '0;
                write_open      <= 1'b0;
                read_open       <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_PUT: begin
          hdr  <= hdr >> BYTE_W;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(HDR_BYTES - 1)) begin
            emit_res <= '{status: ST_OK, cmd: '0, length: '0, from_ram: 1'b0, last: 1'b0};
            if (!write_open) begin
              write_total <= write_cursor;
            end
            state <= S_EMIT;
          end
        end
        S_GET: begin
          if (step != '0) begin
            hdr <= {rd_data, hdr[HDR_W-1:BYTE_W]};
          end
          step <= step + STEP_W'(1);
          if (step == STEP_W'(HDR_BYTES)) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          emit_res.cmd      <= hdr[CMD_W-1:0];
          emit_res.length   <= hl[LEN_W-1:0];
          emit_res.from_ram <= 1'b0;
          emit_res.last     <= 1'b0;
          if (too_long) begin
            emit_res.status <= ST_TOO_LONG;
          end else begin
            emit_res.status <= ST_OK;
            read_cursor     <= read_body;
            read_remaining  <= hl[LEN_W-1:0];
            if (hl == '0) begin
              read_total <= read_body;
            end else begin
              read_open <= 1'b1;
            end
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!p_valid || p_ready) begin
            p_res   <= emit_res;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/variable_length_message_fifo.sv =====
// ---------------------------------------------------------------------------
// Variable length message FIFO: m_tvalid and m_tdata register the result stage.
// Byte, end and reset items: one byte per cycle sustained while m_tready is high.
// Put header writes the header bytes in S_PUT and get header reads them in S_GET
// over the single byte port; the results load as the controller returns to idle.
// Reset clears counters and flags at once; the byte store is not cleared.
// ---------------------------------------------------------------------------
module variable_length_message_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // cmd_code, message_length, max_length, data_byte
  input  logic [vlmf_pkg::IN_DATA_W-1:0]  s_tdata,
  // operation
  input  logic [vlmf_pkg::OP_W-1:0]       s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // cmd_out, length_out, byte_out, zero pad
  output logic [vlmf_pkg::OUT_DATA_W-1:0] m_tdata,
  // status
  output logic [vlmf_pkg::ST_W-1:0]       m_tuser,
  output logic                           m_tlast
);

  import vlmf_pkg::*;

  logic [CMD_W-1:0]  cmd_code;
  logic [LEN_W-1:0]  message_length;
  logic [LEN_W-1:0]  max_length;
  logic [BYTE_W-1:0] data_byte;
  logic              p_valid;
  logic              p_ready;
  res_t              p_res;
  ram_req_t          ram_req;
  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] byte_sel;

  assign cmd_code       = s_tdata[CMD_W-1:0];
  assign message_length = s_tdata[CMD_W+LEN_W-1:CMD_W];
  assign max_length     = s_tdata[CMD_W+2*LEN_W-1:CMD_W+LEN_W];
  assign data_byte      = s_tdata[IN_DATA_W-1:CMD_W+2*LEN_W];

  vlmf_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .op             (op_t'(s_tuser)),
    .cmd_code       (cmd_code),
    .message_length (message_length),
    .max_length     (max_length),
    .data_byte      (data_byte),
    .p_valid        (p_valid),
    .p_res          (p_res),
    .p_ready        (p_ready),
    .ram_req        (ram_req),
    .rd_data        (rd_data)
  );

  vlmf_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (BYTE_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (rd_data)
  );

  assign p_ready  = !m_tvalid || m_tready;
  assign byte_sel = p_res.from_ram ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (p_ready) begin
      m_tvalid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid && p_ready) begin
      m_tdata <= {{PAD_W{1'b0}}, byte_sel, p_res.length, p_res.cmd};
      m_tuser <= p_res.status;
      m_tlast <= p_res.last;
    end
  end

endmodule

// ===== src/vlmf_checker.sv =====
// ---------------------------------------------------------------------------
// Message FIFO checker
// Port-level properties of the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "variable_length_message_fifo_defines.svh"

module vlmf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [vlmf_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [vlmf_pkg::ST_W-1:0]       m_tuser,
  input logic                           m_tlast
);

  import vlmf_pkg::*;

  `VLMF_ASSERT_ALWAYS(a_rst_quiet, rst |=> !m_tvalid, "result valid right after reset")

  `VLMF_ASSERT(a_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)), "stalled result changed")

  `VLMF_ASSERT(a_last_ok, (m_tvalid && m_tlast) |-> (m_tuser == ST_OK), "last byte flagged on a failed transfer")

  `VLMF_ASSERT(a_fail_clean, (m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_EMPTY || m_tuser == ST_ENDED || m_tuser == ST_SEQ)) |-> (m_tdata == '0 && !m_tlast), "failed transfer carries data")

endmodule

bind variable_length_message_fifo vlmf_checker u_vlmf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Message FIFO testbench
// Streams put, get, end and reset items through the message FIFO. A table of
// directed items covers the corner cases, then a bounded run of random message
// traffic follows, running past its minimum until the read position wraps.
// Every result transfer is compared with its table reply or a predicted ring state.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vlmf_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
  localparam int RAND_MIN    = 860;
  localparam int RAND_MAX    = 900;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1000000;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    status_t           status;
    logic [CMD_W-1:0]  cmd;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] data;
    logic              last;
  } fifo_reply_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CMD_W-1:0]  cmd;
    logic [LEN_W-1:0]  mlen;
    logic [LEN_W-1:0]  maxl;
    logic [BYTE_W-1:0] dbyte;
    logic              typed;
    fifo_reply_t       reply;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [OP_W-1:0]       s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [ST_W-1:0]       m_tuser;
  logic                  m_tlast;

  // Predicted ring buffer state.
  logic [BYTE_W-1:0] ring_bytes [CAPACITY];
  pos_t wr_commit = '0;
  pos_t rd_commit = '0;
  pos_t wr_ptr = '0;
  pos_t rd_ptr = '0;
  int   wr_left = 0;
  int   rd_left = 0;
  bit   wr_busy = 1'b0;
  bit   rd_busy = 1'b0;
  bit   queue_ended = 1'b0;

  fifo_reply_t awaited_replies [$];
  int mismatches = 0;
  int sent_count = 0;
  int got_count = 0;
  bit src_idle = 1'b1;
  bit sink_idle = 1'b1;
  bit read_lapped = 1'b0;

  stim_row_t directed_rows [25] = '{
    '{OP_GET_HDR,   32'h0,         12'd0,    12'd0,    8'h00, 1'b1,
      '{ST_EMPTY, '0, '0, '0, 1'b0}},
    '{OP_GET_BYTE,  32'h0,         12'd0,    12'd0,    8'h00, 1'b1,
      '{ST_SEQ, '0, '0, '0, 1'b0}},
    '{OP_PUT_BYTE,  32'h0,         12'd0,    12'd0,    8'hFF, 1'b1,
      '{ST_SEQ, '0, '0, '0, 1'b0}},
    '{OP_UNUSED_LO, 32'hFFFF_FFFF, 12'd4095, 12'd4095, 8'hFF, 1'b1,
      '{ST_SEQ, '0, '0, '0, 1'b0}},
    '{OP_UNUSED_HI, 32'h0,         12'd0,    12'd0,    8'h00, 1'b1,
      '{ST_SEQ, '0, '0, '0, 1'b0}},
    '{OP_PUT_HDR,   32'hFFFF_FFFF, 12'd4089, 12'd0,    8'h00, 1'b1,
      '{ST_FULL, '0, '0, '0, 1'b0}},
    '{OP_PUT_HDR,   32'h0,         12'd4095, 12'd0,    8'h00, 1'b1,
      '{ST_FULL, '0, '0, '0, 1'b0}},
    '{OP_PUT_HDR,   32'hA5C3_0F01, 12'd0,    12'd0,    8'h00, 1'b1,
      '{ST_OK, '0, '0, '0, 1'b0}},
    '{OP_PUT_HDR,   32'h0000_0001, 12'd4088, 12'd0,    8'h00, 1'b1,
      '{ST_FULL, '0, '0, '0, 1'b0}},
    '{OP_GET_HDR,   32'h0,         12'd0,    12'd0,    8'h00, 1'b1,
      '{ST_OK, 32'hA5C3_0F01, 12'd0, '0, 1'b0}},
    '{OP_PUT_HDR,   32'hFFFF_FFFF, 12'd4088, 12'd0,    8'h00, 1'b1,
      '{ST_OK, '0, '0, '0, 1'b0}},
    '{OP_PUT_HDR,   32'h0000_0002, 12'd1,    12'd0,    8'h00, 1'b1,
      '{ST_SEQ, '0, '0, '0, 1'b0}},
    '{OP_PUT_BYTE,  32'h0,         12'd0,    12'd0,    8'hFF, 1'b1,
      '{ST_OK, '0, '0, '0, 1'b0}},
    '{OP_PUT_BYTE,  32'h0,         12'd0,    12'd0,    8'h00, 1'b1,
      '{ST_OK, '0, '0, '0, 1'b0}},
    '{OP_RESET,     32'h0,         12'd0,    12'd0,    8'h00, 1'b1,
      '{ST_OK, '0, '0, '0, 1'b0}},
    '{OP_PUT_HDR,   32'h1234_5678, 12'd2,    12'd0,    8'h00, 1'b0,
      '{ST_OK, '0, '0, '0, 1'b0}},
    '{OP_PUT_BYTE,  32'h0,         12'd0,    12'd0,    8'h5A, 1'b0,
      '{ST_OK, '0, '0, '0, 1'b0}},
    '{OP_PUT_BYTE,  32'h0,         12'd0,    12'd0,    8'hA5, 1'b0,
      '{ST_OK, '0, '0, '0, 1'b0}},
    '{OP_GET_HDR,   32'h0,         12'd0,    12'd1,    8'h00, 1'b1,
      '{ST_TOO_LONG, 32'h1234_5678, 12'd2, '0, 1'b0}},
    '{OP_GET_HDR,   32'h0,         12'd0,    12'd2,    8'h00, 1'b1,
      '{ST_OK, 32'h1234_5678, 12'd2, '0, 1'b0}},
    '{OP_GET_HDR,   32'h0,         12'd0,    12'd4095, 8'h00, 1'b1,
      '{ST_SEQ, '0, '0, '0, 1'b0}},
    '{OP_GET_BYTE,  32'h0,         12'd0,    12'd0,    8'h00, 1'b1,
      '{ST_OK, '0, '0, 8'h5A, 1'b0}},
    '{OP_GET_BYTE,  32'h0,         12'd0,    12'd0,    8'h00, 1'b1,
      '{ST_OK, '0, '0, 8'hA5, 1'b1}},
    '{OP_END,       32'h0,         12'd0,    12'd0,    8'h00, 1'b1,
      '{ST_OK, '0, '0, '0, 1'b0}},
    '{OP_GET_HDR,   32'h0,         12'd0,    12'd4095, 8'h00, 1'b1,
      '{ST_ENDED, '0, '0, '0, 1'b0}}
  };

  variable_length_message_fifo dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #6ns clk = ~clk;

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic void store_word(pos_t p, logic [31:0] w);
    for (int i = 0; i < 4; i++) begin
      pos_t q;
      q = p + pos_t'(i);
      ring_bytes[q[ADDR_W-1:0]] = w[8*i +: 8];
    end
  endfunction

  function automatic logic [31:0] load_word(pos_t p);
    logic [31:0] w;
    w = '0;
    for (int i = 0; i < 4; i++) begin
      pos_t q;
      q = p + pos_t'(i);
      w[8*i +: 8] = ring_bytes[q[ADDR_W-1:0]];
    end
    return w;
  endfunction

  // Applies one accepted item to the predicted ring and returns its result.
  function automatic fifo_reply_t apply_to_ring(logic [OP_W-1:0] op, logic [CMD_W-1:0] cmd,
                                                logic [LEN_W-1:0] mlen, logic [LEN_W-1:0] maxl,
                                                logic [BYTE_W-1:0] dbyte);
    fifo_reply_t r;
    pos_t        fill;
    logic [31:0] hlen;
    r = '{ST_SEQ, '0, '0, '0, 1'b0};
    fill = wr_commit - rd_commit;
    case (op)
      OP_PUT_HDR: begin
        if (wr_busy) begin
          r.status = ST_SEQ;
        end else if (HDR_BYTES + int'(mlen) > CAPACITY ||
                     int'(fill) + HDR_BYTES + int'(mlen) > CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          store_word(wr_commit, cmd);
          store_word(wr_commit + pos_t'(4), 32'(mlen));
          wr_ptr = wr_commit + pos_t'(HDR_BYTES);
          wr_left = int'(mlen);
          if (mlen == 0) wr_commit = wr_ptr;
          else wr_busy = 1'b1;
          r.status = ST_OK;
        end
      end
      OP_PUT_BYTE: begin
        if (wr_busy) begin
          ring_bytes[wr_ptr[ADDR_W-1:0]] = dbyte;
          wr_ptr = wr_ptr + pos_t'(1);
          wr_left--;
          if (wr_left == 0) begin
            wr_commit = wr_ptr;
            wr_busy = 1'b0;
          end
          r.status = ST_OK;
        end
      end
      OP_GET_HDR: begin
        if (rd_busy) begin
          r.status = ST_SEQ;
        end else if (fill == 0) begin
          r.status = queue_ended ? ST_ENDED : ST_EMPTY;
        end else begin
          hlen = load_word(rd_commit + pos_t'(4));
          r.cmd = load_word(rd_commit);
          r.length = hlen[LEN_W-1:0];
          if (hlen > 32'(maxl)) begin
            r.status = ST_TOO_LONG;
          end else begin
            rd_ptr = rd_commit + pos_t'(HDR_BYTES);
            rd_left = int'(hlen);
            if (hlen == 0) rd_commit = rd_ptr;
            else rd_busy = 1'b1;
            r.status = ST_OK;
          end
        end
      end
      OP_GET_BYTE: begin
        if (rd_busy) begin
          r.data = ring_bytes[rd_ptr[ADDR_W-1:0]];
          rd_ptr = rd_ptr + pos_t'(1);
          rd_left--;
          if (rd_left == 0) begin
            rd_commit = rd_ptr;
            rd_busy = 1'b0;
            r.last = 1'b1;
          end
          r.status = ST_OK;
        end
      end
      OP_END: begin
        queue_ended = 1'b1;
        r.status = ST_OK;
      end
      OP_RESET: begin
        wr_commit = '0;
        rd_commit = '0;
        wr_ptr = '0;
        rd_ptr = '0;
        wr_left = 0;
        rd_left = 0;
        wr_busy = 1'b0;
        rd_busy = 1'b0;
        r.status = ST_OK;
      end
      default: r.status = ST_SEQ;
    endcase
    return r;
  endfunction

  task automatic offer(input logic [OP_W-1:0] op, input logic [CMD_W-1:0] cmd,
                       input logic [LEN_W-1:0] mlen, input logic [LEN_W-1:0] maxl,
                       input logic [BYTE_W-1:0] dbyte, input logic typed,
                       input fifo_reply_t typed_reply);
    int          gap;
    pos_t        rd_before;
    fifo_reply_t want;
    gap = src_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {dbyte, maxl, mlen, cmd};
    s_tuser <= op;
    do @(posedge clk); while (!s_tready);
    rd_before = rd_commit;
    want = apply_to_ring(op, cmd, mlen, maxl, dbyte);
    if (op != OP_RESET && rd_commit < rd_before) read_lapped = 1'b1;
    awaited_replies.push_back(typed ? typed_reply : want);
    sent_count++;
    if (sent_count % 50 == 0) src_idle = ($urandom_range(0, 3) != 0);
  endtask

  task automatic drain_wait();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_replies.size() != 0);
  endtask

  initial begin : stimulus
    fifo_reply_t       blank;
    logic [OP_W-1:0]   op;
    logic [CMD_W-1:0]  cmd;
    logic [LEN_W-1:0]  mlen;
    logic [LEN_W-1:0]  maxl;
    logic [BYTE_W-1:0] dbyte;
    logic [31:0]       head;
    int                rand_count;
    int                write_bias;
    int                fill;
    int                room;
    int                roll;
    blank = '{ST_SEQ, '0, '0, '0, 1'b0};
    rand_count = 0;
    write_bias = 50;
    while (rst) @(posedge clk);

    foreach (directed_rows[i]) begin
      offer(directed_rows[i].op, directed_rows[i].cmd, directed_rows[i].mlen,
            directed_rows[i].maxl, directed_rows[i].dbyte, directed_rows[i].typed,
            directed_rows[i].reply);
    end
    drain_wait();

    // Mostly well-formed message traffic, with a little out-of-sequence noise,
    // for a bounded number of items, a little longer until the read position wraps.
    while ((rand_count < RAND_MIN || !read_lapped) && rand_count < RAND_MAX) begin
      if (rand_count % 150 == 0) write_bias = $urandom_range(35, 65);
      if (rand_count == RAND_MIN / 2) drain_wait();
      fill = int'(pos_t'(wr_commit - rd_commit));
      room = CAPACITY - HDR_BYTES - fill;
      cmd = $urandom;
      dbyte = BYTE_W'($urandom);
      maxl = LEN_W'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 80) mlen = '0;
      else if (roll < 91) mlen = LEN_W'($urandom_range(1, 6));
      else if (roll < 97) mlen = LEN_W'($urandom_range(7, 40));
      else if (roll < 98) mlen = LEN_W'($urandom_range(41, 200));
      else mlen = LEN_W'($urandom_range(4095, (room < 0) ? 0 : room + 1));
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        op = OP_W'($urandom_range(0, 7));
        if (op == OP_RESET && $urandom_range(0, 9) != 0) op = OP_UNUSED_HI;
      end else if ($urandom_range(0, 99) < write_bias ||
                   (fill == 0 && !rd_busy && $urandom_range(0, 9) != 0)) begin
        op = wr_busy ? OP_PUT_BYTE : OP_PUT_HDR;
      end else begin
        op = rd_busy ? OP_GET_BYTE : OP_GET_HDR;
        if (fill != 0) begin
          head = load_word(rd_commit + pos_t'(4));
          roll = $urandom_range(0, 99);
          if (roll < 70) maxl = '1;
          else if (roll < 82) maxl = head[LEN_W-1:0];
          else if (roll < 90 && head != 0) maxl = head[LEN_W-1:0] - 1'b1;
        end
      end
      offer(op, cmd, mlen, maxl, dbyte, 1'b0, blank);
      rand_count++;
    end

    drain_wait();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : result_sink
    fifo_reply_t got;
    fifo_reply_t want;
    int          stall;
    while (rst) @(posedge clk);
    forever begin
      if (got_count == 200 || got_count == 2000) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = sink_idle ? $urandom_range(0, 4) : 0;
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.status = status_t'(m_tuser);
      got.cmd = m_tdata[CMD_W-1:0];
      got.length = m_tdata[CMD_W +: LEN_W];
      got.data = m_tdata[CMD_W+LEN_W +: BYTE_W];
      got.last = m_tlast;
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: unexpected transfer, status %0d cmd %h len %0d byte %h last %b",
                   got_count, m_tuser, got.cmd, got.length, got.data, got.last);
      end else begin
        want = awaited_replies.pop_front();
        if (got.status !== want.status || got.cmd !== want.cmd ||
            got.length !== want.length || got.data !== want.data ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected status %0d cmd %h len %0d byte %h last %b, %s",
                     got_count, want.status, want.cmd, want.length, want.data, want.last,
                     $sformatf("got status %0d cmd %h len %0d byte %h last %b",
                               m_tuser, got.cmd, got.length, got.data, got.last));
        end
      end
      got_count++;
      if (got_count % 50 == 0) sink_idle = ($urandom_range(0, 3) != 0);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/vlmf_pkg.sv
src/vlmf_ram.sv
src/vlmf_ctrl.sv
src/variable_length_message_fifo.sv
src/vlmf_checker.sv
sim/tb.sv
